// ===== rtl/core/glyph_word_tile_blitter_macros.svh =====
// Assertion macros for the glyph word tile blitter.
// Used by glyph_word_tile_blitter.sv; needs clk and rst_n in scope.
`ifndef GLYPH_WORD_TILE_BLITTER_MACROS_SVH
`define GLYPH_WORD_TILE_BLITTER_MACROS_SVH
`ifndef SYNTHESIS
`define GWTB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GWTB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GWTB_ASSERT_SAME(label, ante, cons, msg)
`define GWTB_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/core/gwtb_pkg.sv =====
// Package for the glyph word tile blitter: field widths and default geometry.
// No dependencies.
package gwtb_pkg;

    localparam int COORD_W   = 11;
    localparam int PATTERN_W = 16;
    localparam int COUNT_W   = 5;
    localparam int ADDR_W    = 18;
    localparam int COLOUR_W  = 16;
    localparam int WORD_BITS = 16;

    localparam int DEF_SCREEN_WIDTH  = 480;
    localparam int DEF_SCREEN_HEIGHT = 320;
    localparam int DEF_SCALE         = 2;

    localparam logic [COLOUR_W-1:0] FG_RESET = 16'hFFFF;

endpackage

// ===== rtl/core/glyph_word_tile_blitter.sv =====
// Glyph word tile blitter: expands one glyph row word into framebuffer writes.
// Depends on gwtb_pkg and glyph_word_tile_blitter_macros.svh.
//
// Channel  Dir  Handshake               Payload
// -------  ---  ----------------------  -----------------------------------------
// cfg      in   cfg_valid / cfg_ready   cfg_data (foreground colour, RGB565)
// in       in   in_valid / in_ready     tile_x, tile_y, pattern_word, bit_count
// out      out  out_valid / out_ready   pixel_address, pixel_colour, last_write
//
// Steps: accept, then the row base walk (one step per bit of tile_y up to its
// highest set bit, plus a final step), then one step per off-screen tile walked
// (left of the screen, or all when none is on screen) and SCALE*SCALE writes per
// on-screen tile. Off-screen row or zero bit count: done in the accept cycle.
// The output register stalls the tile walk only; the last write of an item can
// sit in it while the next item is accepted. Reset needs no clearing pass.
`include "glyph_word_tile_blitter_macros.svh"

module glyph_word_tile_blitter #(
    parameter int SCREEN_WIDTH  = gwtb_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = gwtb_pkg::DEF_SCREEN_HEIGHT,
    parameter int SCALE         = gwtb_pkg::DEF_SCALE
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gwtb_pkg::COLOUR_W-1:0]        cfg_data,
    // glyph word input
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [gwtb_pkg::COORD_W-1:0]  tile_x,
    input  logic signed [gwtb_pkg::COORD_W-1:0]  tile_y,
    input  logic [gwtb_pkg::PATTERN_W-1:0]       pattern_word,
    input  logic [gwtb_pkg::COUNT_W-1:0]         bit_count,
    // pixel write output
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [gwtb_pkg::ADDR_W-1:0]          pixel_address,
    output logic [gwtb_pkg::COLOUR_W-1:0]        pixel_colour,
    output logic                                 last_write
);
    import gwtb_pkg::*;

    localparam int TILES_W    = SCREEN_WIDTH / SCALE;
    localparam int TILES_H    = SCREEN_HEIGHT / SCALE;
    localparam int ROW_BITS   = $clog2(TILES_H);
    localparam int ROW_STRIDE = SCREEN_WIDTH * SCALE;
    localparam int SUB_W      = (SCALE > 1) ? $clog2(SCALE) : 1;
    localparam int TX_W       = COORD_W + 1;   // tile_x plus up to 15 steps
    localparam int ADDR_SPAN  = SCREEN_WIDTH * SCREEN_HEIGHT;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_EMIT
    } state_t;

    state_t                      state_reg, state_next;
    logic [COLOUR_W-1:0]         fg_reg, fg_next;
    // row base multiplier: shift-and-add, one bit of tile_y per cycle
    logic [ROW_BITS-1:0]         mplier_reg, mplier_next;
    logic [ADDR_W-1:0]           mcand_reg, mcand_next;
    // tile walk
    logic [ADDR_W-1:0]           tile_addr_reg, tile_addr_next;
    logic [ADDR_W-1:0]           pix_off_reg, pix_off_next;
    logic signed [TX_W-1:0]      tx_reg, tx_next;
    logic [PATTERN_W-1:0]        pattern_reg, pattern_next;
    logic [COUNT_W-1:0]          tiles_left_reg, tiles_left_next;
    logic [SUB_W-1:0]            row_reg, row_next;
    logic [SUB_W-1:0]            col_reg, col_next;
    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]           pixel_address_reg, pixel_address_next;
    logic [COLOUR_W-1:0]         pixel_colour_reg, pixel_colour_next;
    logic                        last_write_reg, last_write_next;

    logic                        in_fire;
    logic                        y_on_screen;
    logic [COUNT_W-1:0]          count_sat;
    logic signed [ADDR_W-1:0]    tx_ext;
    logic                        on_screen;
    logic                        last_sub;
    logic                        last_tile;
    logic                        out_free;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;

    assign y_on_screen = !tile_y[COORD_W-1]
                         && ($unsigned(tile_y) < COORD_W'(TILES_H));
    assign count_sat   = (bit_count > COUNT_W'(WORD_BITS)) ? COUNT_W'(WORD_BITS) : bit_count;
    assign tx_ext      = ADDR_W'(tile_x);

    assign on_screen = !tx_reg[TX_W-1] && ($unsigned(tx_reg) < TX_W'(TILES_W));
    assign last_sub  = (col_reg == SUB_W'(SCALE - 1)) && (row_reg == SUB_W'(SCALE - 1));
    // on-screen tiles are contiguous: the last one is either the final bit or
    // the rightmost screen column
    assign last_tile = (tiles_left_reg == COUNT_W'(1)) || (tx_reg == TX_W'(TILES_W - 1));
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        logic advance_tile;
        advance_tile       = 1'b0;
        state_next         = state_reg;
        fg_next            = fg_reg;
        mplier_next        = mplier_reg;
        mcand_next         = mcand_reg;
        tile_addr_next     = tile_addr_reg;
        pix_off_next       = pix_off_reg;
        tx_next            = tx_reg;
        pattern_next       = pattern_reg;
        tiles_left_next    = tiles_left_reg;
        row_next           = row_reg;
        col_next           = col_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        pixel_address_next = pixel_address_reg;
        pixel_colour_next  = pixel_colour_reg;
        last_write_next    = last_write_reg;

        if (cfg_valid && cfg_ready)
        begin
            fg_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && y_on_screen && (count_sat != '0))
                begin
                    state_next      = S_MUL;
                    mplier_next     = tile_y[ROW_BITS-1:0];
                    mcand_next      = ADDR_W'(ROW_STRIDE);
                    // column part of the first tile; wraps harmlessly when negative
                    tile_addr_next  = ADDR_W'(tx_ext * ADDR_W'(SCALE));
                    pix_off_next    = '0;
                    tx_next         = TX_W'(tile_x);
                    pattern_next    = pattern_word;
                    tiles_left_next = count_sat;
                    row_next        = '0;
                    col_next        = '0;
                end
            end
            S_MUL:
            begin
                if (mplier_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        tile_addr_next = tile_addr_reg + mcand_reg;
                    end
                    mplier_next = mplier_reg >> 1;
                    mcand_next  = mcand_reg << 1;
                end
            end
            S_EMIT:
            begin
                if (on_screen)
                begin
                    if (out_free)
                    begin
                        out_valid_next     = 1'b1;
                        pixel_address_next = tile_addr_reg + pix_off_reg;
                        pixel_colour_next  = pattern_reg[PATTERN_W-1] ? fg_reg : '0;
                        last_write_next    = last_sub && last_tile;
                        if (last_sub)
                        begin
                            advance_tile = 1'b1;
                        end
                        else if (col_reg == SUB_W'(SCALE - 1))
                        begin
                            col_next     = '0;
                            row_next     = row_reg + SUB_W'(1);
                            pix_off_next = pix_off_reg + ADDR_W'(SCREEN_WIDTH - (SCALE - 1));
                        end
                        else
                        begin
                            col_next     = col_reg + SUB_W'(1);
                            pix_off_next = pix_off_reg + ADDR_W'(1);
                        end
                    end
                end
                else
                begin
                    advance_tile = 1'b1;
                end

                if (advance_tile)
                begin
                    tx_next         = tx_reg + TX_W'(1);
                    pattern_next    = pattern_reg << 1;
                    tiles_left_next = tiles_left_reg - COUNT_W'(1);
                    tile_addr_next  = tile_addr_reg + ADDR_W'(SCALE);
                    pix_off_next    = '0;
                    row_next        = '0;
                    col_next        = '0;
                    if (tiles_left_reg == COUNT_W'(1) || (on_screen && last_tile))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            fg_reg            <= FG_RESET;
            mplier_reg        <= '0;
            mcand_reg         <= '0;
            tile_addr_reg     <= '0;
            pix_off_reg       <= '0;
            tx_reg            <= '0;
            pattern_reg       <= '0;
            tiles_left_reg    <= '0;
            row_reg           <= '0;
            col_reg           <= '0;
            out_valid_reg     <= 1'b0;
            pixel_address_reg <= '0;
            pixel_colour_reg  <= '0;
            last_write_reg    <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            fg_reg            <= fg_next;
            mplier_reg        <= mplier_next;
            mcand_reg         <= mcand_next;
            tile_addr_reg     <= tile_addr_next;
            pix_off_reg       <= pix_off_next;
            tx_reg            <= tx_next;
            pattern_reg       <= pattern_next;
            tiles_left_reg    <= tiles_left_next;
            row_reg           <= row_next;
            col_reg           <= col_next;
            out_valid_reg     <= out_valid_next;
            pixel_address_reg <= pixel_address_next;
            pixel_colour_reg  <= pixel_colour_next;
            last_write_reg    <= last_write_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_address = pixel_address_reg;
    assign pixel_colour  = pixel_colour_reg;
    assign last_write    = last_write_reg;

    // tile walk never runs with no tiles left
    `GWTB_ASSERT_SAME(a_tiles_left, state_reg == S_EMIT, tiles_left_reg != '0, "tile walk with zero tiles left")
    // a word on an off-screen tile row produces no work
    `GWTB_ASSERT_NEXT(a_row_drop, in_fire && !y_on_screen, state_reg == S_IDLE, "off-screen row started a walk")
    // every write lands inside the framebuffer when the span fits the address
    `GWTB_ASSERT_SAME(a_addr_range, out_valid_reg && (ADDR_SPAN <= (1 << ADDR_W)), pixel_address_reg < ADDR_W'(ADDR_SPAN - 1) || pixel_address_reg == ADDR_W'(ADDR_SPAN - 1), "pixel address beyond framebuffer")

endmodule
